@@ rtl/stt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Token kinds, lexer modes, keyword table and helpers for the schema tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	typedef enum logic [4:0] {
		TK_UNKNOWN  = 5'd0,
		TK_EOF      = 5'd1,
		TK_NAME     = 5'd2,
		TK_NUMBER   = 5'd3,
		TK_PKG      = 5'd4,
		TK_DEF      = 5'd5,
		TK_ENUM     = 5'd6,
		TK_ASSIGN   = 5'd7,
		TK_TYPE_SEP = 5'd8,
		TK_SEMI     = 5'd9,
		TK_ITEM_SEP = 5'd10,
		TK_LBRACE   = 5'd11,
		TK_RBRACE   = 5'd12,
		TK_LANGLE   = 5'd13,
		TK_RANGLE   = 5'd14,
		TK_INT8     = 5'd15,
		TK_INT16    = 5'd16,
		TK_INT32    = 5'd17,
		TK_INT64    = 5'd18,
		TK_UINT8    = 5'd19,
		TK_UINT16   = 5'd20,
		TK_UINT32   = 5'd21,
		TK_UINT64   = 5'd22,
		TK_STR8     = 5'd23,
		TK_STR16    = 5'd24,
		TK_STR32    = 5'd25,
		TK_STR64    = 5'd26,
		TK_LIST8    = 5'd27,
		TK_LIST16   = 5'd28,
		TK_LIST32   = 5'd29,
		TK_LIST64   = 5'd30
	} tok_kind_t;

	typedef enum logic [6:0] {
		MODE_IDLE       = 7'b0000001,
		MODE_NAME       = 7'b0000010,
		MODE_NUMBER     = 7'b0000100,
		MODE_SLASH      = 7'b0001000,
		MODE_LINE       = 7'b0010000,
		MODE_BLOCK      = 7'b0100000,
		MODE_BLOCK_STAR = 7'b1000000
	} mode_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [15:0] length;
		logic [30:0] value;
		logic [15:0] line;
		logic [15:0] column;
		logic        last;
	} tok_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	localparam logic [30:0] NUM_MAX = 31'h7fffffff;
	localparam int KW_MAX_LEN = 8;
	localparam int KW_COUNT   = 29;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = 2;

	typedef struct packed {
		logic [63:0] text;
		logic [3:0]  len;
		tok_kind_t   kind;
	} kw_entry_t;

	// text is right-justified: last character in the low byte
	localparam kw_entry_t KW_ROM [KW_COUNT] = '{
		'{text: "byte",     len: 4'd4, kind: TK_INT8},
		'{text: "def",      len: 4'd3, kind: TK_DEF},
		'{text: "enum",     len: 4'd4, kind: TK_ENUM},
		'{text: "pkg",      len: 4'd3, kind: TK_PKG},
		'{text: "int",      len: 4'd3, kind: TK_INT32},
		'{text: "int8",     len: 4'd4, kind: TK_INT8},
		'{text: "int16",    len: 4'd5, kind: TK_INT16},
		'{text: "int32",    len: 4'd5, kind: TK_INT32},
		'{text: "int64",    len: 4'd5, kind: TK_INT64},
		'{text: "long",     len: 4'd4, kind: TK_INT64},
		'{text: "short",    len: 4'd5, kind: TK_INT16},
		'{text: "uint",     len: 4'd4, kind: TK_UINT32},
		'{text: "uint8",    len: 4'd5, kind: TK_UINT8},
		'{text: "uint16",   len: 4'd6, kind: TK_UINT16},
		'{text: "uint32",   len: 4'd6, kind: TK_UINT32},
		'{text: "uint64",   len: 4'd6, kind: TK_UINT64},
		'{text: "ubyte",    len: 4'd5, kind: TK_UINT8},
		'{text: "ushort",   len: 4'd6, kind: TK_UINT16},
		'{text: "ulong",    len: 4'd5, kind: TK_UINT64},
		'{text: "string",   len: 4'd6, kind: TK_STR8},
		'{text: "string8",  len: 4'd7, kind: TK_STR8},
		'{text: "string16", len: 4'd8, kind: TK_STR16},
		'{text: "string32", len: 4'd8, kind: TK_STR32},
		'{text: "string64", len: 4'd8, kind: TK_STR64},
		'{text: "list",     len: 4'd4, kind: TK_LIST8},
		'{text: "list8",    len: 4'd5, kind: TK_LIST8},
		'{text: "list16",   len: 4'd6, kind: TK_LIST16},
		'{text: "list32",   len: 4'd6, kind: TK_LIST32},
		'{text: "list64",   len: 4'd6, kind: TK_LIST64}
	};

	// name holds the first characters with character 0 in the low byte
	function automatic tok_kind_t kw_lookup(input logic [63:0] name, input logic [3:0] len);
		tok_kind_t kind;
		logic      hit;
		logic [2:0] j;
		kind = TK_NAME;
		for (int e = 0; e < KW_COUNT; e++) begin
			hit = (KW_ROM[e].len == len);
			for (int k = 0; k < KW_MAX_LEN; k++) begin
				j = 3'(int'(KW_ROM[e].len) - 1 - k);
				if (k < int'(KW_ROM[e].len)) begin
					hit = hit & (name[8*k +: 8] == KW_ROM[e].text[{j, 3'b000} +: 8]);
				end
			end
			if (hit) begin
				kind = KW_ROM[e].kind;
			end
		end
		return kind;
	endfunction

	function automatic tok_kind_t punct_kind(input logic [7:0] b);
		tok_kind_t kind;
		case (b)
			"=": kind = TK_ASSIGN;
			":": kind = TK_TYPE_SEP;
			";": kind = TK_SEMI;
			",": kind = TK_ITEM_SEP;
			"{": kind = TK_LBRACE;
			"}": kind = TK_RBRACE;
			"<": kind = TK_LANGLE;
			">": kind = TK_RANGLE;
			default: kind = TK_UNKNOWN;
		endcase
		return kind;
	endfunction

	function automatic logic [15:0] clip16(input logic [31:0] v);
		return (v > 32'hffff) ? 16'hffff : v[15:0];
	endfunction

endpackage

@@ rtl/schema_text_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schema_text_tokenizer
// Byte-serial lexer for schema text: skips blanks and comments, gives names,
// keywords, numbers, punctuation, unknown bytes and a final EOF token.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser      | tlast
//  s_axis  | in  | char_byte                          | -          | end_of_text
//  m_axis  | out | token_length, number_value,        | token_kind | last_in_run
//          |     | start_line, start_column, pad      |            |
//
// One byte is taken per cycle while s_axis_tready is high; its tokens (none, one or two)
// land in a four-word output queue in the same cycle and leave one word per cycle while
// m_axis_tready is high. s_axis_tready is low while the queue holds more than two words.
// Reset (arst_n low) empties the queue and sets line 1, column 0, idle mode.
// An end_of_text word flushes the pending token, gives EOF and restarts.
// ----------------------------------------------------------------------------
module schema_text_tokenizer #(
	parameter int KEYWORD_BUFFER_BYTES = 8,
	parameter int POSITION_BITS        = 16,
	parameter int LENGTH_BITS          = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // char_byte
	input  logic        s_axis_tlast,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // token_length, number_value, start_line, start_column, pad
	output logic [4:0]  m_axis_tuser,   // token_kind
	output logic        m_axis_tlast    // last_in_run
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0]   LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	stt_pkg::mode_t              mode_q, mode_d;
	logic [7:0]                  nb_q [KEYWORD_BUFFER_BYTES];
	logic [7:0]                  nb_d [KEYWORD_BUFFER_BYTES];
	logic [LENGTH_BITS-1:0]      run_q, run_d;
	logic [30:0]                 acc_q, acc_d;
	logic [POSITION_BITS-1:0]    line_q, line_d, col_q, col_d, tsl_q, tsl_d, tsc_q, tsc_d;
	logic                        cr_q, cr_d;

	stt_pkg::tok_t               q_q [stt_pkg::QDEPTH];
	logic [stt_pkg::QPTR_BITS-1:0] wp_q, rp_q;
	logic [2:0]                  cnt_q;
	stt_pkg::tok_t               tok_a, tok_b, head;
	logic [1:0]                  n_push;
	logic                        fire, pop;

	assign s_axis_tready = (cnt_q <= 3'd2);
	assign fire = s_axis_tvalid & s_axis_tready;
	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign pop = m_axis_tvalid & m_axis_tready;
	assign head = q_q[rp_q];
	assign m_axis_tdata = {1'b0, head.column, head.line, head.value, head.length};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

	always_comb begin
		logic [7:0]               b;
		logic                     is_cr, is_lf, is_ws, is_digit, is_alpha;
		stt_pkg::tok_kind_t       pk;
		logic                     flush, idle_go, sec_v;
		stt_pkg::tok_t            pend, sec;
		logic [POSITION_BITS-1:0] col_inc;
		logic [LENGTH_BITS-1:0]   run_inc;
		logic [63:0]              name8;
		logic [34:0]              prod;
		logic [30:0]              digit;

		b        = s_axis_tdata;
		is_cr    = (b == stt_pkg::CH_CR);
		is_lf    = (b == stt_pkg::CH_LF);
		is_ws    = is_cr | is_lf | (b == stt_pkg::CH_SPACE) | (b == stt_pkg::CH_TAB);
		is_digit = (b >= "0") && (b <= "9");
		is_alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
		pk       = stt_pkg::punct_kind(b);
		digit    = 31'(b - "0");
		col_inc  = (col_q == POS_MAX) ? col_q : col_q + POS_ONE;
		run_inc  = (run_q == LEN_MAX) ? run_q : run_q + LENGTH_BITS'(1);
		prod     = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {4'b0000, digit};

		for (int k = 0; k < stt_pkg::KW_MAX_LEN; k++) begin
			name8[8*k +: 8] = nb_q[k];
		end

		// pending token as it would be flushed now
		pend.kind   = stt_pkg::TK_UNKNOWN;
		pend.length = 16'd1;
		pend.value  = '0;
		pend.line   = stt_pkg::clip16(32'(tsl_q));
		pend.column = stt_pkg::clip16(32'(tsc_q));
		pend.last   = 1'b0;
		if (mode_q == stt_pkg::MODE_NAME) begin
			pend.kind   = (run_q > LENGTH_BITS'(stt_pkg::KW_MAX_LEN)) ? stt_pkg::TK_NAME
				: stt_pkg::kw_lookup(name8, run_q[3:0]);
			pend.length = stt_pkg::clip16(32'(run_q));
		end else if (mode_q == stt_pkg::MODE_NUMBER) begin
			pend.kind   = stt_pkg::TK_NUMBER;
			pend.length = stt_pkg::clip16(32'(run_q));
			pend.value  = acc_q;
		end

		sec.kind   = stt_pkg::TK_UNKNOWN;
		sec.length = 16'd1;
		sec.value  = '0;
		sec.line   = stt_pkg::clip16(32'(line_q));
		sec.column = stt_pkg::clip16(32'(col_inc));
		sec.last   = 1'b1;
		sec_v      = 1'b0;

		mode_d  = mode_q;
		nb_d    = nb_q;
		run_d   = run_q;
		acc_d   = acc_q;
		line_d  = line_q;
		col_d   = col_q;
		tsl_d   = tsl_q;
		tsc_d   = tsc_q;
		cr_d    = cr_q;
		flush   = 1'b0;
		idle_go = 1'b0;

		if (s_axis_tlast) begin
			flush      = (mode_q == stt_pkg::MODE_NAME) || (mode_q == stt_pkg::MODE_NUMBER)
				|| (mode_q == stt_pkg::MODE_SLASH);
			sec.kind   = stt_pkg::TK_EOF;
			sec.length = 16'd0;
			sec_v      = 1'b1;
			mode_d     = stt_pkg::MODE_IDLE;
			run_d      = '0;
			acc_d      = '0;
			line_d     = POS_ONE;
			col_d      = '0;
			tsl_d      = POS_ONE;
			tsc_d      = POS_ONE;
			cr_d       = 1'b0;
		end else begin
			case (mode_q)
				stt_pkg::MODE_NAME: begin
					if (is_alpha | is_digit) begin
						for (int k = 0; k < KEYWORD_BUFFER_BYTES; k++) begin
							if (32'(run_q) == k) begin
								nb_d[k] = b;
							end
						end
						run_d = run_inc;
					end else begin
						flush   = 1'b1;
						idle_go = 1'b1;
					end
				end
				stt_pkg::MODE_NUMBER: begin
					if (is_digit) begin
						acc_d = (prod > {4'b0000, stt_pkg::NUM_MAX}) ? stt_pkg::NUM_MAX
							: prod[30:0];
						run_d = run_inc;
					end else begin
						flush   = 1'b1;
						idle_go = 1'b1;
					end
				end
				stt_pkg::MODE_SLASH: begin
					if (b == stt_pkg::CH_SLASH) begin
						mode_d = stt_pkg::MODE_LINE;
					end else if (b == stt_pkg::CH_STAR) begin
						mode_d = stt_pkg::MODE_BLOCK_STAR;
					end else begin
						flush   = 1'b1;
						idle_go = 1'b1;
					end
				end
				stt_pkg::MODE_LINE: begin
					if (is_cr | is_lf) begin
						mode_d = stt_pkg::MODE_IDLE;
					end
				end
				stt_pkg::MODE_BLOCK, stt_pkg::MODE_BLOCK_STAR: begin
					if ((mode_q == stt_pkg::MODE_BLOCK_STAR) && (b == stt_pkg::CH_SLASH)) begin
						mode_d = stt_pkg::MODE_IDLE;
					end else if (b == stt_pkg::CH_STAR) begin
						mode_d = stt_pkg::MODE_BLOCK_STAR;
					end else begin
						mode_d = stt_pkg::MODE_BLOCK;
					end
				end
				default: begin
					idle_go = 1'b1;
				end
			endcase

			if (flush) begin
				mode_d = stt_pkg::MODE_IDLE;
			end

			if (idle_go && !is_ws) begin
				if (pk != stt_pkg::TK_UNKNOWN) begin
					sec.kind = pk;
					sec_v    = 1'b1;
				end else if (is_digit) begin
					mode_d = stt_pkg::MODE_NUMBER;
					tsl_d  = line_q;
					tsc_d  = col_inc;
					run_d  = LENGTH_BITS'(1);
					acc_d  = digit;
				end else if (is_alpha) begin
					mode_d   = stt_pkg::MODE_NAME;
					tsl_d    = line_q;
					tsc_d    = col_inc;
					run_d    = LENGTH_BITS'(1);
					nb_d[0]  = b;
				end else if (b == stt_pkg::CH_SLASH) begin
					mode_d = stt_pkg::MODE_SLASH;
					tsl_d  = line_q;
					tsc_d  = col_inc;
					run_d  = LENGTH_BITS'(1);
				end else begin
					sec_v = 1'b1;
				end
			end

			// line breaks; LF right after CR belongs to the same break
			if (is_cr | (is_lf & ~cr_q)) begin
				line_d = (line_q == POS_MAX) ? line_q : line_q + POS_ONE;
			end
			col_d = (is_cr | is_lf) ? '0 : col_inc;
			cr_d  = is_cr;
		end

		pend.last = ~sec_v;
		tok_a  = flush ? pend : sec;
		tok_b  = sec;
		n_push = fire ? (2'(flush) + 2'(sec_v)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MODE_IDLE;
			run_q  <= '0;
			acc_q  <= '0;
			line_q <= POS_ONE;
			col_q  <= '0;
			tsl_q  <= POS_ONE;
			tsc_q  <= POS_ONE;
			cr_q   <= 1'b0;
			wp_q   <= '0;
			rp_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (fire) begin
				mode_q <= mode_d;
				run_q  <= run_d;
				acc_q  <= acc_d;
				line_q <= line_d;
				col_q  <= col_d;
				tsl_q  <= tsl_d;
				tsc_q  <= tsc_d;
				cr_q   <= cr_d;
			end
			wp_q  <= wp_q + stt_pkg::QPTR_BITS'(n_push);
			rp_q  <= rp_q + stt_pkg::QPTR_BITS'(pop);
			cnt_q <= cnt_q + 3'(n_push) - 3'(pop);
		end
	end

	// name buffer and queue words carry no reset
	always_ff @(posedge clk) begin
		if (fire) begin
			nb_q <= nb_d;
		end
		if (n_push != 2'd0) begin
			q_q[wp_q] <= tok_a;
		end
		if (n_push == 2'd2) begin
			q_q[wp_q + stt_pkg::QPTR_BITS'(1)] <= tok_b;
		end
	end

endmodule
